// ===== sv/irbd_pkg.sv =====
// Package: shared types, register indexes, defaults and code constants of the beacon decoder.
`timescale 1ns / 1ps
`default_nettype none

package irbd_pkg;

    localparam int WIDTH_W   = 16;
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CODE_W    = 8;
    localparam int PRES_W    = 2;

    localparam int DEF_RING_DEPTH = 3;
    localparam int DEF_CHANNELS   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX   = 3'd5;

    localparam logic [REG_W-1:0] RST_START_MIN = 16'd4400;
    localparam logic [REG_W-1:0] RST_START_MAX = 16'd4900;
    localparam logic [REG_W-1:0] RST_ZERO_MIN  = 16'd350;
    localparam logic [REG_W-1:0] RST_ZERO_MAX  = 16'd850;
    localparam logic [REG_W-1:0] RST_ONE_MIN   = 16'd1400;
    localparam logic [REG_W-1:0] RST_ONE_MAX   = 16'd1850;

    localparam logic [CODE_W-1:0] CODE_TWO    = 8'd2;
    localparam logic [CODE_W-1:0] CODE_DOCK_A = 8'd80;
    localparam logic [CODE_W-1:0] CODE_DOCK_B = 8'd160;

    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_START,
        CLS_ZERO,
        CLS_ONE
    } pulse_class_t;

    typedef struct packed {
        logic [REG_W-1:0] start_min;
        logic [REG_W-1:0] start_max;
        logic [REG_W-1:0] zero_min;
        logic [REG_W-1:0] zero_max;
        logic [REG_W-1:0] one_min;
        logic [REG_W-1:0] one_max;
    } window_cfg_t;

endpackage

`default_nettype wire

// ===== sv/irbd_if.sv =====
// Interfaces: pulse/query request channel and presence result channel.
`timescale 1ns / 1ps
`default_nettype none

interface irbd_req_if
    import irbd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               operation;
    logic               channel;
    logic [WIDTH_W-1:0] pulse_width;

    modport source (output valid, output operation, output channel, output pulse_width,
                    input ready);
    modport sink   (input valid, input operation, input channel, input pulse_width,
                    output ready);
endinterface

interface irbd_res_if
    import irbd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PRES_W-1:0] presence;

    modport source (output valid, output presence, input ready);
    modport sink   (input valid, input presence, output ready);
endinterface

`default_nettype wire

// ===== sv/irbd_window_classify.sv =====
// Pulse width classifier: exclusive-bound window compares, start then zero then one.
`timescale 1ns / 1ps
`default_nettype none

module irbd_window_classify
    import irbd_pkg::*;
(
    input  window_cfg_t        cfg,
    input  logic [WIDTH_W-1:0] pulse_width,
    output pulse_class_t       pulse_class
);

    logic in_start;
    logic in_zero;
    logic in_one;

    assign in_start = (pulse_width > cfg.start_min) && (pulse_width < cfg.start_max);
    assign in_zero  = (pulse_width > cfg.zero_min)  && (pulse_width < cfg.zero_max);
    assign in_one   = (pulse_width > cfg.one_min)   && (pulse_width < cfg.one_max);

    always_comb
    begin
        if (in_start)
        begin
            pulse_class = CLS_START;
        end
        else if (in_zero)
        begin
            pulse_class = CLS_ZERO;
        end
        else if (in_one)
        begin
            pulse_class = CLS_ONE;
        end
        else
        begin
            pulse_class = CLS_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ir_pulse_width_beacon_decoder_top.sv =====
// Top level: two-channel IR docking beacon decoder with per-channel code rings.
`timescale 1ns / 1ps
`default_nettype none
// Results: a query request gives its presence result in the output register, loaded at the
//   accepting edge; pulse requests give no result and update ring state at the accepting edge.
// Throughput: one request per cycle; ready drops only while a result sits in the output
//   register and the sink does not take it (the single output register sets this).
// Reset (async, active low): window registers to 4400/4900/350/850/1400/1850, all code
//   slots zero, slot pointers to RING_DEPTH (no start seen), output register empty.

module ir_pulse_width_beacon_decoder_top
    import irbd_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int CHANNELS   = DEF_CHANNELS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    irbd_req_if.sink                  pulse_in,
    irbd_res_if.source                result_out,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_data
);

    // pointer must hold RING_DEPTH itself as the "no start yet" mark
    localparam int PTR_W = $clog2(RING_DEPTH + 1);

    window_cfg_t cfg_reg;

    logic [PTR_W-1:0]  ptr_reg  [CHANNELS];
    logic [PTR_W-1:0]  ptr_next [CHANNELS];
    logic [CODE_W-1:0] ring_reg  [CHANNELS][RING_DEPTH];
    logic [CODE_W-1:0] ring_next [CHANNELS][RING_DEPTH];

    logic              out_valid_reg;
    logic [PRES_W-1:0] presence_reg;
    logic [PRES_W-1:0] presence_next;

    logic         req_fire;
    logic         is_pulse;
    logic         is_query;
    pulse_class_t pulse_class;

    logic seen_two  [CHANNELS];
    logic seen_dock [CHANNELS];
    logic ring_zero [CHANNELS];

    // ---------------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_min <= RST_START_MIN;
            cfg_reg.start_max <= RST_START_MAX;
            cfg_reg.zero_min  <= RST_ZERO_MIN;
            cfg_reg.zero_max  <= RST_ZERO_MAX;
            cfg_reg.one_min   <= RST_ONE_MIN;
            cfg_reg.one_max   <= RST_ONE_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_MIN: cfg_reg.start_min <= cfg_data;
                REG_START_MAX: cfg_reg.start_max <= cfg_data;
                REG_ZERO_MIN:  cfg_reg.zero_min  <= cfg_data;
                REG_ZERO_MAX:  cfg_reg.zero_max  <= cfg_data;
                REG_ONE_MIN:   cfg_reg.one_min   <= cfg_data;
                REG_ONE_MAX:   cfg_reg.one_max   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Request handshake: the output register parts the two sides
    // ---------------------------------------------------------------------
    assign pulse_in.ready = !out_valid_reg || result_out.ready;
    assign req_fire       = pulse_in.valid && pulse_in.ready;
    assign is_pulse       = req_fire && (pulse_in.operation == OP_PULSE);
    assign is_query       = req_fire && (pulse_in.operation == OP_QUERY);

    irbd_window_classify u_classify (
        .cfg         (cfg_reg),
        .pulse_width (pulse_in.pulse_width),
        .pulse_class (pulse_class)
    );

    // ---------------------------------------------------------------------
    // Per-channel ring scan (independent per slot)
    // ---------------------------------------------------------------------
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            seen_two[c]  = 1'b0;
            seen_dock[c] = 1'b0;
            ring_zero[c] = 1'b1;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                if (ring_reg[c][i] == CODE_TWO)
                begin
                    seen_two[c] = 1'b1;
                end
                if ((ring_reg[c][i] == CODE_DOCK_A) || (ring_reg[c][i] == CODE_DOCK_B))
                begin
                    seen_dock[c] = 1'b1;
                end
                if (ring_reg[c][i] != '0)
                begin
                    ring_zero[c] = 1'b0;
                end
            end
        end
    end

    // channel numbers without a receiver report nothing
    always_comb
    begin
        presence_next = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (int'(pulse_in.channel) == c)
            begin
                presence_next = {seen_dock[c], seen_two[c]};
            end
        end
    end

    // ---------------------------------------------------------------------
    // Pointer and slot next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            logic hit;
            hit         = (int'(pulse_in.channel) == c);
            ptr_next[c] = ptr_reg[c];
            if (is_pulse && hit && (pulse_class == CLS_START))
            begin
                // wrap, and the no-start mark also lands on slot 0
                if (ptr_reg[c] >= PTR_W'(RING_DEPTH - 1))
                begin
                    ptr_next[c] = '0;
                end
                else
                begin
                    ptr_next[c] = ptr_reg[c] + PTR_W'(1);
                end
            end

            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_next[c][i] = ring_reg[c][i];
                if (is_query && hit)
                begin
                    ring_next[c][i] = '0;
                end
                else if (is_pulse && hit)
                begin
                    case (pulse_class)
                        CLS_START:
                        begin
                            if (ptr_next[c] == PTR_W'(i))
                            begin
                                ring_next[c][i] = '0;
                            end
                        end
                        CLS_ZERO:
                        begin
                            if (ptr_reg[c] == PTR_W'(i))
                            begin
                                ring_next[c][i] = {ring_reg[c][i][CODE_W-2:0], 1'b0};
                            end
                        end
                        CLS_ONE:
                        begin
                            if (ptr_reg[c] == PTR_W'(i))
                            begin
                                ring_next[c][i] = {ring_reg[c][i][CODE_W-2:0], 1'b1};
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                ptr_reg[c] <= PTR_W'(RING_DEPTH);
                for (int i = 0; i < RING_DEPTH; i++)
                begin
                    ring_reg[c][i] <= '0;
                end
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                ptr_reg[c] <= ptr_next[c];
                for (int i = 0; i < RING_DEPTH; i++)
                begin
                    ring_reg[c][i] <= ring_next[c][i];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (is_query)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            presence_reg <= presence_next;
        end
    end

    assign result_out.valid    = out_valid_reg;
    assign result_out.presence = presence_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_query_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        is_query |=> result_out.valid)
        else $error("query request did not produce a result");

    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !result_out.ready) |=> (result_out.valid && $stable(presence_reg)))
        else $error("pending result lost or changed while stalled");

    generate
        for (genvar g = 0; g < CHANNELS; g++)
        begin : g_chk
            a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
                ptr_reg[g] <= PTR_W'(RING_DEPTH))
                else $error("slot pointer out of range");

            a_query_clears: assert property (@(posedge clk) disable iff (!rst_n)
                (is_query && (int'(pulse_in.channel) == g)) |=> ring_zero[g])
                else $error("query did not clear the ring");

            a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
                (is_pulse && (int'(pulse_in.channel) == g) && (pulse_class == CLS_START))
                |=> (ptr_reg[g] != PTR_W'(RING_DEPTH)))
                else $error("start pulse left pointer unarmed");
        end
    endgenerate

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the IR beacon decoder: directed rows, framed random traffic, live prediction.
`timescale 1ns / 1ps

module tb_top
    import irbd_pkg::*;
();

    // Block geometry at its default build
    localparam int RING_LEN = DEF_RING_DEPTH;
    localparam int NUM_CH   = DEF_CHANNELS;
    localparam int SEL_W    = $clog2(RING_LEN + 1);

    // Presence codes of a query result
    localparam logic [PRES_W-1:0] PRES_NONE = 2'd0;
    localparam logic [PRES_W-1:0] PRES_TWO  = 2'd1;
    localparam logic [PRES_W-1:0] PRES_BOTH = 2'd3;

    // One row of the directed stimulus; pinned rows carry a hand-typed presence
    typedef struct {
        logic              op;
        logic              ch;
        logic [WIDTH_W-1:0] width;
        logic              pinned;
        logic [PRES_W-1:0] presence;
    } beacon_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_data;

    // Sink-side ready and idling control
    logic sink_ready = 1'b0;
    bit   idle_on = 1'b1;

    // Hand-typed expectation riding along with the request it belongs to
    logic              pin_on;
    logic [PRES_W-1:0] pin_pres;

    // Shadow of the block: window bounds, code slots, slot selectors
    logic [REG_W-1:0]  win_cfg [6];
    logic [CODE_W-1:0] code_slots [NUM_CH][RING_LEN];
    logic [SEL_W-1:0]  slot_sel [NUM_CH];

    // Presence values owed by the block, oldest first
    logic [PRES_W-1:0] presence_due [$];
    int mismatch_count = 0;

    irbd_req_if req_if ();
    irbd_res_if res_if ();

    assign res_if.ready = sink_ready;

    ir_pulse_width_beacon_decoder_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pulse_in   (req_if),
        .result_out (res_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    // Directed rows at the reset windows: start 4400..4900, zero 350..850, one 1400..1850
    beacon_row_t dir_rows [23] = '{
        '{OP_QUERY, 1'b0, 16'd0,     1'b1, PRES_NONE},   // empty ring after reset
        '{OP_PULSE, 1'b0, 16'd1600,  1'b0, PRES_NONE},   // bit before any start: dropped
        '{OP_PULSE, 1'b0, 16'd4401,  1'b0, PRES_NONE},   // start, just above min
        '{OP_PULSE, 1'b0, 16'd1849,  1'b0, PRES_NONE},   // one, just below max
        '{OP_PULSE, 1'b0, 16'd351,   1'b0, PRES_NONE},   // zero, just above min -> code 2
        '{OP_PULSE, 1'b0, 16'd0,     1'b0, PRES_NONE},   // width floor: ignored
        '{OP_PULSE, 1'b0, 16'hFFFF,  1'b0, PRES_NONE},   // width ceiling: ignored
        '{OP_PULSE, 1'b0, 16'd4400,  1'b0, PRES_NONE},   // bound itself is outside
        '{OP_PULSE, 1'b0, 16'd850,   1'b0, PRES_NONE},   // bound itself is outside
        '{OP_QUERY, 1'b0, 16'd0,     1'b1, PRES_TWO},
        '{OP_PULSE, 1'b0, 16'd1401,  1'b0, PRES_NONE},   // pointer kept across query
        '{OP_PULSE, 1'b0, 16'd600,   1'b0, PRES_NONE},
        '{OP_PULSE, 1'b0, 16'd1600,  1'b0, PRES_NONE},
        '{OP_PULSE, 1'b0, 16'd849,   1'b0, PRES_NONE},
        '{OP_PULSE, 1'b0, 16'd849,   1'b0, PRES_NONE},
        '{OP_PULSE, 1'b0, 16'd849,   1'b0, PRES_NONE},
        '{OP_PULSE, 1'b0, 16'd849,   1'b0, PRES_NONE},   // slot 0 now holds 80
        '{OP_PULSE, 1'b0, 16'd4899,  1'b0, PRES_NONE},   // start, just below max: slot 1
        '{OP_PULSE, 1'b0, 16'd1600,  1'b0, PRES_NONE},
        '{OP_PULSE, 1'b0, 16'd600,   1'b0, PRES_NONE},   // slot 1 holds 2
        '{OP_QUERY, 1'b0, 16'd0,     1'b1, PRES_BOTH},
        '{OP_PULSE, 1'b1, 16'd4900,  1'b0, PRES_NONE},   // upper start bound: ignored
        '{OP_QUERY, 1'b1, 16'hFFFF,  1'b1, PRES_NONE}    // other channel untouched
    };

    // Apply one pulse to the shadow state; windows tried in order start, zero, one
    function automatic void decode_pulse(logic ch, logic [WIDTH_W-1:0] w);
        pulse_class_t cls;
        cls = CLS_NONE;
        if (w > win_cfg[REG_START_MIN] && w < win_cfg[REG_START_MAX])
            cls = CLS_START;
        else if (w > win_cfg[REG_ZERO_MIN] && w < win_cfg[REG_ZERO_MAX])
            cls = CLS_ZERO;
        else if (w > win_cfg[REG_ONE_MIN] && w < win_cfg[REG_ONE_MAX])
            cls = CLS_ONE;
        case (cls)
            CLS_START:
            begin
                slot_sel[ch] = (slot_sel[ch] >= SEL_W'(RING_LEN - 1)) ? '0 : slot_sel[ch] + 1'b1;
                code_slots[ch][slot_sel[ch]] = '0;
            end
            CLS_ZERO:
            begin
                // no start yet on this channel: the bit is dropped
                if (slot_sel[ch] < SEL_W'(RING_LEN))
                    code_slots[ch][slot_sel[ch]] = {code_slots[ch][slot_sel[ch]][CODE_W-2:0], 1'b0};
            end
            CLS_ONE:
            begin
                if (slot_sel[ch] < SEL_W'(RING_LEN))
                    code_slots[ch][slot_sel[ch]] = {code_slots[ch][slot_sel[ch]][CODE_W-2:0], 1'b1};
            end
            default:
            begin
            end
        endcase
    endfunction

    // Scan a channel's ring for the beacon codes, then clear it (selector stays)
    function automatic logic [PRES_W-1:0] query_ring(logic ch);
        logic seen_two;
        logic seen_dock;
        seen_two = 1'b0;
        seen_dock = 1'b0;
        for (int i = 0; i < RING_LEN; i++)
        begin
            if (code_slots[ch][i] == CODE_TWO)
                seen_two = 1'b1;
            else if (code_slots[ch][i] == CODE_DOCK_A || code_slots[ch][i] == CODE_DOCK_B)
                seen_dock = 1'b1;
            code_slots[ch][i] = '0;
        end
        return {seen_dock, seen_two};
    endfunction

    // Pick a width strictly inside (lo, hi); fall back to any width if the window is empty
    function automatic logic [WIDTH_W-1:0] pick_width(logic [REG_W-1:0] lo, logic [REG_W-1:0] hi);
        int l;
        int h;
        l = lo;
        h = hi;
        if (h > l + 1)
            return WIDTH_W'($urandom_range(h - 1, l + 1));
        return WIDTH_W'($urandom);
    endfunction

    // Sink: drops ready now and then while idling is on
    always @(posedge clk)
        sink_ready <= !idle_on || ($urandom_range(99) >= 6);

    // Monitor: everything sampled at the edge, before this edge's updates land
    always @(posedge clk)
    begin
        logic [PRES_W-1:0] due;
        if (rst_n)
        begin
            if (cfg_we)
                win_cfg[cfg_index] = cfg_data;
            if (res_if.valid && res_if.ready)
            begin
                if (presence_due.size() == 0)
                begin
                    $error("presence: expected nothing, actual %0d", res_if.presence);
                    mismatch_count++;
                end
                else
                begin
                    due = presence_due.pop_front();
                    if (res_if.presence !== due)
                    begin
                        $error("presence: expected %0d, actual %0d", due, res_if.presence);
                        mismatch_count++;
                    end
                end
            end
            if (req_if.valid && req_if.ready)
            begin
                if (req_if.operation == OP_PULSE)
                    decode_pulse(req_if.channel, req_if.pulse_width);
                else
                begin
                    // shadow state is updated even when the row pins its own value
                    due = query_ring(req_if.channel);
                    presence_due.push_back(pin_on ? pin_pres : due);
                end
            end
        end
    end

    // Issue one request and hold it until accepted; may idle first
    task automatic send_req(input logic op, input logic ch, input logic [WIDTH_W-1:0] w,
                            input logic pinned, input logic [PRES_W-1:0] pres);
        while (idle_on && $urandom_range(99) < 6)
        begin
            req_if.valid <= 1'b0;
            req_if.pulse_width <= WIDTH_W'($urandom);
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.operation <= op;
        req_if.channel <= ch;
        req_if.pulse_width <= w;
        pin_on <= pinned;
        pin_pres <= pres;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every owed result has come back
    task automatic hold_until_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (presence_due.size() != 0)
            @(posedge clk);
        // pulses finish at their accepting edge; a short margin covers the output register
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Load all six window bounds; called only with the block drained
    task automatic load_windows(input logic [REG_W-1:0] s_lo, input logic [REG_W-1:0] s_hi,
                                input logic [REG_W-1:0] z_lo, input logic [REG_W-1:0] z_hi,
                                input logic [REG_W-1:0] o_lo, input logic [REG_W-1:0] o_hi);
        write_reg(REG_START_MIN, s_lo);
        write_reg(REG_START_MAX, s_hi);
        write_reg(REG_ZERO_MIN, z_lo);
        write_reg(REG_ZERO_MAX, z_hi);
        write_reg(REG_ONE_MIN, o_lo);
        write_reg(REG_ONE_MAX, o_hi);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random traffic: mostly whole frames (start + code bits), plus queries,
    // stray pulses, truncated or over-long frames and the odd full drain
    task automatic run_phase(input int quota);
        int sent;
        int pick;
        int nbits;
        logic ch;
        logic bit_val;
        logic [CODE_W-1:0] code;
        sent = 0;
        while (sent < quota)
        begin
            pick = $urandom_range(99);
            ch = 1'($urandom_range(1));
            if (pick < 50)
            begin
                case ($urandom_range(4))
                    0, 1: code = CODE_TWO;
                    2: code = CODE_DOCK_A;
                    3: code = CODE_DOCK_B;
                    default: code = CODE_W'($urandom);
                endcase
                // extra leading bits overflow the slot; short frames break the code
                nbits = ($urandom_range(9) == 0) ? $urandom_range(7, 1) : 8 + $urandom_range(3);
                send_req(OP_PULSE, ch, pick_width(win_cfg[REG_START_MIN], win_cfg[REG_START_MAX]),
                         1'b0, PRES_NONE);
                for (int i = nbits - 1; i >= 0; i--)
                begin
                    bit_val = (i < CODE_W) ? code[i] : 1'($urandom_range(1));
                    if (bit_val)
                        send_req(OP_PULSE, ch,
                                 pick_width(win_cfg[REG_ONE_MIN], win_cfg[REG_ONE_MAX]),
                                 1'b0, PRES_NONE);
                    else
                        send_req(OP_PULSE, ch,
                                 pick_width(win_cfg[REG_ZERO_MIN], win_cfg[REG_ZERO_MAX]),
                                 1'b0, PRES_NONE);
                end
                sent += nbits + 1;
            end
            else if (pick < 72)
            begin
                send_req(OP_QUERY, ch, WIDTH_W'($urandom), 1'b0, PRES_NONE);
                sent++;
            end
            else if (pick < 74)
                hold_until_drained();
            else
            begin
                // stray pulse: any width, or a lone bit in the zero window
                if ($urandom_range(1))
                    send_req(OP_PULSE, ch, WIDTH_W'($urandom), 1'b0, PRES_NONE);
                else
                    send_req(OP_PULSE, ch,
                             pick_width(win_cfg[REG_ZERO_MIN], win_cfg[REG_ZERO_MAX]),
                             1'b0, PRES_NONE);
                sent++;
            end
        end
        hold_until_drained();
    endtask

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int s_lo;
        int z_lo;
        int o_lo;

        // Shadow state as the block comes out of reset
        win_cfg[REG_START_MIN] = RST_START_MIN;
        win_cfg[REG_START_MAX] = RST_START_MAX;
        win_cfg[REG_ZERO_MIN] = RST_ZERO_MIN;
        win_cfg[REG_ZERO_MAX] = RST_ZERO_MAX;
        win_cfg[REG_ONE_MIN] = RST_ONE_MIN;
        win_cfg[REG_ONE_MAX] = RST_ONE_MAX;
        for (int c = 0; c < NUM_CH; c++)
        begin
            slot_sel[c] = SEL_W'(RING_LEN);
            for (int i = 0; i < RING_LEN; i++)
                code_slots[c][i] = '0;
        end

        req_if.valid <= 1'b0;
        req_if.operation <= OP_PULSE;
        req_if.channel <= 1'b0;
        req_if.pulse_width <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_START_MIN;
        cfg_data <= '0;
        pin_on <= 1'b0;
        pin_pres <= PRES_NONE;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        foreach (dir_rows[i])
            send_req(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].width,
                     dir_rows[i].pinned, dir_rows[i].presence);
        hold_until_drained();

        // Reset windows
        run_phase(170);

        // Disjoint windows, all moved
        load_windows(16'd2000, 16'd2600, 16'd100, 16'd400, 16'd700, 16'd1100);
        run_phase(170);

        // Overlap: start wins over zero, zero over one; one window spans everything
        load_windows(16'd1000, 16'd2000, 16'd500, 16'd1500, 16'd0, 16'hFFFF);
        run_phase(170);

        // Extremes: start takes every width but the two end values
        load_windows(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        run_phase(60);

        // Every window empty, one of them with min + 1 == max
        load_windows(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd5, 16'd6);
        run_phase(30);

        // Random windows of random size
        s_lo = $urandom_range(60000);
        z_lo = $urandom_range(60000);
        o_lo = $urandom_range(60000);
        load_windows(REG_W'(s_lo), REG_W'(s_lo + $urandom_range(5000, 2)),
                     REG_W'(z_lo), REG_W'(z_lo + $urandom_range(5000, 2)),
                     REG_W'(o_lo), REG_W'(o_lo + $urandom_range(5000, 2)));
        run_phase(120);

        // Back to reset values, with both sides running flat out
        idle_on = 1'b0;
        load_windows(RST_START_MIN, RST_START_MAX, RST_ZERO_MIN, RST_ZERO_MAX,
                     RST_ONE_MIN, RST_ONE_MAX);
        run_phase(120);

        // All results are in; let the output register settle before the verdict
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
